@@ src/fnv_pkg.sv @@
// shared types and constants for the fnv-1 hash bucket unit
`default_nettype none

package fnv_pkg;

    // field widths
    localparam int HASH_W = 32;
    localparam int BKT_W  = 31;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = $clog2(HASH_W);

    // fnv-1 32-bit constants
    localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME        = 32'h0100_0193;

    // bucket count after reset
    localparam logic [BKT_W-1:0] BUCKET_COUNT_RST = 31'd1024;

    // queue occupancy flags seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // remainder unit states
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

`default_nettype wire

@@ src/fnv1_hash_bucket_unit.sv @@
// top level of the fnv-1 hash bucket unit
// byte words: accepted one per cycle while the key queue has room; no result
// end words: result offered after the queue pop and the bit-serial remainder loop
//   (one dividend bit per cycle, 32 steps); with zero buckets the loop is skipped
// back end takes a new key only once the last result is taken; keys wait in a two-entry queue
// reset (synchronous, active low): hash to the offset basis, bucket count 1024, queue empty
`default_nettype none

module fnv1_hash_bucket_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [fnv_pkg::BKT_W-1:0] i_cfg_wr_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,   // [7:0] key_byte
    input  wire logic                      s_axis_tuser,   // [0] is_end
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [31:0]                    m_axis_tdata    // [30:0] bucket_index, [31] zero
);
    import fnv_pkg::*;

    logic [BKT_W-1:0]  r_bucket_count;
    t_q_flags          w_q_flags;
    logic              w_push;
    logic [HASH_W-1:0] w_push_data;
    logic              w_pop;
    logic [HASH_W-1:0] w_pop_data;
    logic [BKT_W-1:0]  w_index;

    // bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_bucket_count <= i_cfg_wr_data;
        end
    end

    // hashing front end
    fnv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_key_byte  (s_axis_tdata),
        .i_is_end    (s_axis_tuser),
        .i_q_flags   (w_q_flags),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // closed-key queue
    fnv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_flags     (w_q_flags)
    );

    // remainder back end
    fnv_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_flags  (w_q_flags),
        .i_q_data   (w_pop_data),
        .o_q_pop    (w_pop),
        .i_divisor  (r_bucket_count),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (w_index)
    );

    assign m_axis_tdata = {1'b0, w_index};

endmodule

`default_nettype wire

@@ src/fnv_front.sv @@
// front end: accepts words, keeps the running hash, queues closed keys
`default_nettype none

module fnv_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [fnv_pkg::BYTE_W-1:0] i_key_byte,
    input  wire logic                       i_is_end,
    input  wire fnv_pkg::t_q_flags          i_q_flags,
    output logic                            o_push,
    output logic [fnv_pkg::HASH_W-1:0]      o_push_data
);
    import fnv_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic              w_accept;

    // accept while the queue has room for a closed key
    assign o_s_tready = !i_q_flags.full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // closed key goes to the queue with the hash as it stands
    assign o_push      = w_accept && i_is_end;
    assign o_push_data = r_hash;

    // hash update: multiply by the prime, then xor in the byte; an end word restores the basis
    always_comb begin
        n_hash = r_hash;
        if (w_accept) begin
            if (i_is_end) begin
                n_hash = FNV_OFFSET_BASIS;
            end else begin
                n_hash = (r_hash * FNV_PRIME) ^ {{(HASH_W-BYTE_W){1'b0}}, i_key_byte};
            end
        end
    end

    // running hash register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_OFFSET_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

`default_nettype wire

@@ src/fnv_queue.sv @@
// two-entry queue of closed-key hashes between front and back
`default_nettype none

module fnv_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [fnv_pkg::HASH_W-1:0] i_push_data,
    input  wire logic                       i_pop,
    output logic [fnv_pkg::HASH_W-1:0]      o_pop_data,
    output fnv_pkg::t_q_flags               o_flags
);
    import fnv_pkg::*;

    logic [HASH_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    assign o_flags.full  = (r_count == 2'd2);
    assign o_flags.empty = (r_count == 2'd0);

    // guard against misuse at the edges
    assign w_push = i_push && !o_flags.full;
    assign w_pop  = i_pop && !o_flags.empty;

    assign o_pop_data = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // fill level never goes beyond the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue fill level out of range");

    // a push onto a full queue would lose a key
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_flags.full))
        else $error("push while queue full");

    // pointers agree with the fill level when empty or full
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_flags.empty || o_flags.full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers inconsistent with fill level");

endmodule

`default_nettype wire

@@ src/fnv_mod.sv @@
// back end: bit-serial remainder of the hash by the bucket count, output register
`default_nettype none

module fnv_mod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire fnv_pkg::t_q_flags          i_q_flags,
    input  wire logic [fnv_pkg::HASH_W-1:0] i_q_data,
    output logic                            o_q_pop,
    input  wire logic [fnv_pkg::BKT_W-1:0]  i_divisor,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [fnv_pkg::BKT_W-1:0]       o_m_tdata
);
    import fnv_pkg::*;

    t_div_state        r_state;
    t_div_state        n_state;
    logic [HASH_W-1:0] r_dvd;
    logic [HASH_W-1:0] n_dvd;
    logic [BKT_W-1:0]  r_rem;
    logic [BKT_W-1:0]  n_rem;
    logic [BKT_W-1:0]  r_divisor;
    logic [BKT_W-1:0]  n_divisor;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [HASH_W-1:0] w_trial;
    logic [HASH_W-1:0] w_diff;
    logic              w_ge;
    logic              w_zero_div;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial    = {r_rem, r_dvd[HASH_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_divisor});
    assign w_diff     = w_trial - {1'b0, r_divisor};
    assign w_zero_div = (i_divisor == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (!i_q_flags.empty) begin
                    n_state = w_zero_div ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_cnt == '0) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (i_m_tready) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop    = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            DIV_IDLE: o_q_pop    = !i_q_flags.empty;
            DIV_RUN:  o_q_pop    = 1'b0;
            DIV_DONE: o_m_tvalid = 1'b1;
            default: begin
                o_q_pop    = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
    end

    assign o_m_tdata = r_rem;

    // datapath next values
    always_comb begin
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        if (r_state == DIV_IDLE && !i_q_flags.empty) begin
            n_dvd     = i_q_data;
            n_rem     = '0;
            n_divisor = i_divisor;
            n_cnt     = CNT_W'(HASH_W - 1);
        end else if (r_state == DIV_RUN) begin
            n_dvd = {r_dvd[HASH_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[BKT_W-1:0] : w_trial[BKT_W-1:0];
            n_cnt = r_cnt - 1'b1;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_cnt     <= n_cnt;
    end

    // partial remainder stays below the divisor throughout the run
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN) |-> (r_rem < r_divisor))
        else $error("partial remainder not below divisor");

    // a zero divisor gives a zero bucket index
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_DONE && r_divisor == '0) |-> (r_rem == '0))
        else $error("zero divisor gave non-zero index");

    // a finished run always reaches the output register
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN && r_cnt == '0) |=> (r_state == DIV_DONE))
        else $error("remainder run did not finish");

endmodule

`default_nettype wire

@@ sim/fnv1_hash_bucket_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for the fnv-1 hash bucket unit: keys streamed in, bucket words checked

module fnv1_hash_bucket_unit_tb;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam int unsigned RANDOM_WORDS = 600;
    localparam int unsigned PHASE_WORDS  = 75;
    localparam int unsigned SETTLE       = 40;

    // expected bucket words, kept in order of the end words that cause them
    class hash_bucket_scoreboard;
        logic [31:0]               running_hash;
        logic [fnv_pkg::BKT_W-1:0] buckets;
        logic [fnv_pkg::BKT_W-1:0] bucket_due[$];
        int                        errors;

        function new();
            running_hash = HASH_BASIS;
            buckets      = 31'd1024;
            errors       = 0;
        endfunction

        function void set_buckets(logic [fnv_pkg::BKT_W-1:0] count);
            buckets = count;
        endfunction

        // byte words fold into the hash, end words close the key
        function void note_word(logic [7:0] key_byte, logic is_end);
            if (!is_end) begin
                running_hash = (running_hash * HASH_PRIME) ^ {24'd0, key_byte};
            end else begin
                // a zero bucket count gives bucket 0
                if (buckets == '0)
                    bucket_due.push_back('0);
                else
                    bucket_due.push_back(31'(running_hash % {1'b0, buckets}));
                running_hash = HASH_BASIS;
            end
        endfunction

        function void check_word(logic [31:0] tdata);
            logic [fnv_pkg::BKT_W-1:0] want;
            if (bucket_due.size() == 0) begin
                $display("%0t: unexpected bucket word, expected none, got %0d", $time, tdata);
                errors++;
                return;
            end
            want = bucket_due.pop_front();
            if (tdata[30:0] !== want) begin
                $display("%0t: bucket_index expected %0d, got %0d", $time, want, tdata[30:0]);
                errors++;
            end
            if (tdata[31] !== 1'b0) begin
                $display("%0t: pad bit expected 0, got %b", $time, tdata[31]);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [fnv_pkg::BKT_W-1:0] i_cfg_wr_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;   // [7:0] key_byte
    logic                      s_axis_tuser  = 1'b0; // [0] is_end
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [31:0]               m_axis_tdata;         // [30:0] bucket_index, [31] zero

    hash_bucket_scoreboard sb = new();
    int unsigned words_sent = 0;
    bit          calm       = 1'b0;

    fnv1_hash_bucket_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    initial begin : rx_ready
        int unsigned stall_left;
        int unsigned run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    stall_left = idle_len();
                    run_left   = $urandom_range(1, 12);
                end
                if (stall_left > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready <= 1'b1;
                    run_left--;
                end
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    // one input word, held until taken, then an optional gap
    task automatic send_word(input logic [7:0] key_byte, input logic is_end);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key_byte;
        s_axis_tuser  <= is_end;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_word(key_byte, is_end);
        words_sent++;
        gap = idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random key of the given length, closed by an end word with a junk byte
    task automatic send_key(input int unsigned len);
        logic [7:0] b;
        repeat (len) begin
            b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
            send_word(b, 1'b0);
        end
        send_word(8'($urandom), 1'b1);
    endtask

    // wait for every bucket word, then let the remainder loop settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.bucket_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [fnv_pkg::BKT_W-1:0] count);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_buckets(count);
    endtask

    // stimulus
    initial begin : stimulus
        int unsigned phase;
        int unsigned len;
        int unsigned r;
        int unsigned phase_start;
        logic [fnv_pkg::BKT_W-1:0] setting;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bucket count: empty key with a junk byte, byte extremes, zero byte
        send_word(8'hA5, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h61, 1'b0);
        send_word(8'h00, 1'b1);

        // largest bucket count
        drain();
        write_buckets(31'h7FFF_FFFF);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h7F, 1'b1);

        // single bucket
        drain();
        write_buckets(31'd1);
        send_word(8'h5A, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'h01, 1'b1);

        // zero bucket count, outside the legal range
        drain();
        write_buckets('0);
        send_word(8'h12, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);

        // top bit of the count
        drain();
        write_buckets(31'h4000_0000);
        send_word(8'hFF, 1'b0);
        send_word(8'hFE, 1'b0);
        send_word(8'h00, 1'b1);

        // random keys over a spread of bucket counts
        phase = 0;
        phase_start = words_sent;
        while (words_sent - phase_start < RANDOM_WORDS) begin
            drain();
            case (phase % 8)
                0: setting = 31'h7FFF_FFFF;
                1: setting = 31'd1;
                2: setting = 31'($urandom);
                3: setting = '0;
                4: setting = 31'd1 << $urandom_range(1, 30);
                5: setting = 31'($urandom_range(2, 50));
                6: setting = 31'd1024;
                default: setting = 31'($urandom) | 31'h4000_0000;
            endcase
            write_buckets(setting);
            calm = (phase % 4 == 2);
            r = words_sent;
            while (words_sent - r < PHASE_WORDS) begin
                len = $urandom_range(0, 99);
                if (len < 10)
                    len = 0;
                else if (len < 85)
                    len = $urandom_range(1, 8);
                else if (len < 97)
                    len = $urandom_range(9, 24);
                else
                    len = $urandom_range(40, 64);
                send_key(len);
            end
            phase++;
        end

        drain();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ fnv1_hash_bucket_unit.f @@
src/fnv_pkg.sv
src/fnv_front.sv
src/fnv_queue.sv
src/fnv_mod.sv
src/fnv1_hash_bucket_unit.sv
sim/fnv1_hash_bucket_unit_tb.sv
